[hdl/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Holds the request codes, the status codes, the field widths and the control
// bundle that the queue's control logic hands to every storage cell.
// ----------------------------------------------------------------------------
package spq_pkg;

    // Field widths of one item.
    localparam int unsigned DATA_W = 32;
    localparam int unsigned PRIO_W = 32;
    localparam int unsigned OCC_W  = 5;

    // Request kind carried on the slave-side tuser.
    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_REMOVE = 1'b1
    } req_t;

    // Result status.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Command that every cell sees in the same cycle.
    typedef struct packed {
        logic                     ins;
        logic                     rem;
        logic signed [DATA_W-1:0] new_data;
        logic signed [PRIO_W-1:0] new_prio;
    } cell_ctrl_t;

endpackage

[hdl/spq_cell.sv]
// ----------------------------------------------------------------------------
// spq_cell: one entry of the sorted queue
// Holds one data/priority pair. On an insert it keeps its entry, takes the new
// item or takes its left neighbor's entry; on a remove it takes its right
// neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell
(
    input  logic                                clk,
    input  spq_pkg::cell_ctrl_t                 ctrl,
    input  logic                                occupied,
    input  logic                                left_keep,
    input  logic signed [spq_pkg::DATA_W-1:0]   left_data,
    input  logic signed [spq_pkg::PRIO_W-1:0]   left_prio,
    input  logic signed [spq_pkg::DATA_W-1:0]   right_data,
    input  logic signed [spq_pkg::PRIO_W-1:0]   right_prio,
    output logic                                keep,
    output logic signed [spq_pkg::DATA_W-1:0]   data,
    output logic signed [spq_pkg::PRIO_W-1:0]   prio
);

    logic signed [spq_pkg::DATA_W-1:0] data_reg;
    logic signed [spq_pkg::DATA_W-1:0] data_next;
    logic signed [spq_pkg::PRIO_W-1:0] prio_reg;
    logic signed [spq_pkg::PRIO_W-1:0] prio_next;

    // A held entry of strictly higher priority stays ahead of the new item.
    assign keep = occupied && (prio_reg > ctrl.new_prio);

    // Select the next content of this entry.
    always_comb
    begin
        data_next = data_reg;
        prio_next = prio_reg;
        if (ctrl.ins && !keep)
        begin
            if (left_keep)
            begin
                data_next = ctrl.new_data;
                prio_next = ctrl.new_prio;
            end
            else
            begin
                data_next = left_data;
                prio_next = left_prio;
            end
        end
        else if (ctrl.rem)
        begin
            data_next = right_data;
            prio_next = right_prio;
        end
    end

    // Entry storage; its content is meaningful only below the fill count.
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        prio_reg <= prio_next;
    end

    assign data = data_reg;
    assign prio = prio_reg;

endmodule

[hdl/sorted_priority_queue.sv]
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded priority queue in a row of sorting cells
// Keeps up to CAPACITY entries ordered by descending priority and serves the
// highest priority first; equal priorities are served newest first.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side: s_tuser selects insert or remove, s_tdata carries the data
//   and priority of an insert (ignored on a remove).
//   Master side: one result item per request, carrying the removed entry
//   (zero when none), a valid flag, the status and the occupancy after the
//   request. An insert into a full queue is dropped with a full status, a
//   remove from an empty queue gives an empty status.
//   The result is registered and appears on the cycle after the request is
//   taken. One request is taken per cycle while no result is stalled, set by
//   the single update of the cell row and the one-deep output register; a new
//   request is taken while the previous result is being taken by the receiver.
//   When the receiver stalls, the result holds and s_tready drops until it is
//   taken.
//   Reset empties the queue at once (the fill count clears); entry contents
//   are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module sorted_priority_queue
#(
    parameter int unsigned CAPACITY = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Request items.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // item_data[31:0], item_priority[63:32]
    input  logic        s_tuser,   // req_type[0]
    // Result items.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // out_data[31:0], out_priority[63:32],
                                   // item_valid[64], status[66:65],
                                   // occupancy[71:67]
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam int unsigned EXT_W = (CNT_W > spq_pkg::OCC_W) ? CNT_W : spq_pkg::OCC_W;

    logic [CNT_W-1:0]                  count_reg;
    logic [CNT_W-1:0]                  count_next;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic signed [spq_pkg::DATA_W-1:0] res_data_reg;
    logic signed [spq_pkg::DATA_W-1:0] res_data_next;
    logic signed [spq_pkg::PRIO_W-1:0] res_prio_reg;
    logic signed [spq_pkg::PRIO_W-1:0] res_prio_next;
    logic                              res_item_valid_reg;
    logic                              res_item_valid_next;
    spq_pkg::status_t                  res_status_reg;
    spq_pkg::status_t                  res_status_next;
    logic [spq_pkg::OCC_W-1:0]         res_occ_reg;
    logic [spq_pkg::OCC_W-1:0]         res_occ_next;

    logic                              accept;
    logic                              is_remove;
    logic                              full;
    logic                              empty;
    logic [EXT_W-1:0]                  occ_ext;
    spq_pkg::cell_ctrl_t               ctrl;

    logic                              keep_w [CAPACITY];
    logic signed [spq_pkg::DATA_W-1:0] data_w [CAPACITY];
    logic signed [spq_pkg::PRIO_W-1:0] prio_w [CAPACITY];

    // Request decode.
    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign is_remove = (s_tuser == spq_pkg::REQ_REMOVE);
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign empty     = (count_reg == '0);

    // Command broadcast to the cell row.
    assign ctrl.ins      = accept && !is_remove && !full;
    assign ctrl.rem      = accept && is_remove && !empty;
    assign ctrl.new_data = s_tdata[31:0];
    assign ctrl.new_prio = s_tdata[63:32];

    // Row of cells, front entry at index 0.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                              occ;
        logic                              lk;
        logic signed [spq_pkg::DATA_W-1:0] ld;
        logic signed [spq_pkg::PRIO_W-1:0] lp;
        logic signed [spq_pkg::DATA_W-1:0] rd;
        logic signed [spq_pkg::PRIO_W-1:0] rp;

        assign occ = (count_reg > CNT_W'(i));

        if (i == 0)
        begin : g_first
            assign lk = 1'b1;
            assign ld = '0;
            assign lp = '0;
        end
        else
        begin : g_mid
            assign lk = keep_w[i-1];
            assign ld = data_w[i-1];
            assign lp = prio_w[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign rd = '0;
            assign rp = '0;
        end
        else
        begin : g_inner
            assign rd = data_w[i+1];
            assign rp = prio_w[i+1];
        end

        spq_cell u_cell
        (
            .clk        (clk),
            .ctrl       (ctrl),
            .occupied   (occ),
            .left_keep  (lk),
            .left_data  (ld),
            .left_prio  (lp),
            .right_data (rd),
            .right_prio (rp),
            .keep       (keep_w[i]),
            .data       (data_w[i]),
            .prio       (prio_w[i])
        );
    end

    // Fill count and result formation.
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.ins)
            count_next = count_reg + CNT_W'(1);
        else if (ctrl.rem)
            count_next = count_reg - CNT_W'(1);
        occ_ext = EXT_W'(count_next);

        out_valid_next      = out_valid_reg;
        res_data_next       = res_data_reg;
        res_prio_next       = res_prio_reg;
        res_item_valid_next = res_item_valid_reg;
        res_status_next     = res_status_reg;
        res_occ_next        = res_occ_reg;

        if (m_tready)
            out_valid_next = 1'b0;

        if (accept)
        begin
            out_valid_next      = 1'b1;
            res_data_next       = '0;
            res_prio_next       = '0;
            res_item_valid_next = 1'b0;
            res_status_next     = spq_pkg::ST_OK;
            res_occ_next        = occ_ext[spq_pkg::OCC_W-1:0];
            if (is_remove)
            begin
                if (empty)
                    res_status_next = spq_pkg::ST_EMPTY;
                else
                begin
                    res_data_next       = data_w[0];
                    res_prio_next       = prio_w[0];
                    res_item_valid_next = 1'b1;
                end
            end
            else if (full)
                res_status_next = spq_pkg::ST_FULL;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        res_data_reg       <= res_data_next;
        res_prio_reg       <= res_prio_next;
        res_item_valid_reg <= res_item_valid_next;
        res_status_reg     <= res_status_next;
        res_occ_reg        <= res_occ_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {res_occ_reg, res_status_reg, res_item_valid_reg,
                       res_prio_reg, res_data_reg};

endmodule

[hdl/spq_checker.sv]
// ----------------------------------------------------------------------------
// spq_checker: port-level checks of the sorted priority queue
// Watches the result channel and checks the consistency of each result item
// and that a stalled result holds.
// ----------------------------------------------------------------------------
module spq_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);

    // A stalled result must not change.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // A reported entry always comes with an ok status.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[64] |-> m_tdata[66:65] == spq_pkg::ST_OK)
        else $error("removed entry reported with error status");

    // Without a reported entry the data and priority fields are zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[64] |-> m_tdata[63:0] == 64'd0)
        else $error("nonzero payload without a removed entry");

    // An empty error leaves the queue empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[66:65] == spq_pkg::ST_EMPTY |-> m_tdata[71:67] == 5'd0)
        else $error("empty status with nonzero occupancy");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[sim/sorted_priority_queue_test.sv]
// ----------------------------------------------------------------------------
// sorted_priority_queue_test: self-checking bench for the sorted priority queue
// Feeds insert and remove requests through the slave stream and checks every
// result item against a behavioral copy of the queue held in the bench. The
// copy keeps entries by descending priority, with equal priorities served
// newest first. A directed opening covers the extremes, the full and empty
// cases and ties. Random phases then swing the fill level between empty and
// full, with random gaps on both sides, one long receiver hold-off and
// several points where the sender waits until all results have come back.
// ----------------------------------------------------------------------------
module sorted_priority_queue_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DEPTH = 16;

    // One request waiting to be offered to the queue.
    typedef struct {
        spq_pkg::req_t kind;
        logic [31:0]   data;
        logic [31:0]   prio;
        bit            drain_first;
    } request_t;

    // One result item as the queue should report it.
    typedef struct {
        logic [31:0]      data;
        logic [31:0]      prio;
        logic             valid;
        spq_pkg::status_t status;
        logic [4:0]       occ;
    } outcome_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;    // item_data[31:0], item_priority[63:32]
    logic        s_tuser = 1'b0;  // req_type[0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;         // out_data[31:0], out_priority[63:32],
                                  // item_valid[64], status[66:65],
                                  // occupancy[71:67]

    // Requests not yet taken by the queue, and results still owed by it.
    request_t    request_q[$];
    outcome_t    due_results_q[$];

    // Bench copy of the queue contents, front at index 0.
    logic signed [31:0] held_data [DEPTH];
    logic signed [31:0] held_prio [DEPTH];
    int unsigned        held_count = 0;
    int unsigned        peak_count = 0;

    // Run statistics.
    int unsigned sent_count    = 0;
    int unsigned results_seen  = 0;
    int unsigned mismatches    = 0;
    int unsigned served_count  = 0;
    int unsigned empty_count   = 0;
    int unsigned full_count    = 0;

    // Working variables of the driver and the monitor.
    bit          drv_offer;
    bit          rcv_ready;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    outcome_t    want;
    outcome_t    got;

    sorted_priority_queue #(.CAPACITY(DEPTH)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // Applies one request to the bench copy and returns the result it owes.
    function automatic outcome_t serve_request(request_t r);
        outcome_t    res;
        int unsigned pos;
        res.data   = '0;
        res.prio   = '0;
        res.valid  = 1'b0;
        res.status = spq_pkg::ST_OK;
        if (r.kind == spq_pkg::REQ_INSERT)
        begin
            if (held_count >= DEPTH)
            begin
                res.status = spq_pkg::ST_FULL;
            end
            else
            begin
                // New entry goes behind strictly higher priorities only.
                pos = 0;
                while (pos < held_count && held_prio[pos] > $signed(r.prio))
                    pos++;
                for (int unsigned i = held_count; i > pos; i--)
                begin
                    held_data[i] = held_data[i-1];
                    held_prio[i] = held_prio[i-1];
                end
                held_data[pos] = r.data;
                held_prio[pos] = r.prio;
                held_count++;
                if (held_count > peak_count)
                    peak_count = held_count;
            end
        end
        else
        begin
            if (held_count == 0)
            begin
                res.status = spq_pkg::ST_EMPTY;
            end
            else
            begin
                res.data  = held_data[0];
                res.prio  = held_prio[0];
                res.valid = 1'b1;
                for (int unsigned i = 1; i < held_count; i++)
                begin
                    held_data[i-1] = held_data[i];
                    held_prio[i-1] = held_prio[i];
                end
                held_count--;
            end
        end
        res.occ = held_count[4:0];
        return res;
    endfunction

    task automatic add_request(spq_pkg::req_t kind, logic [31:0] data,
                               logic [31:0] prio, bit drain_first);
        request_t r;
        r.kind        = kind;
        r.data        = data;
        r.prio        = prio;
        r.drain_first = drain_first;
        request_q.push_back(r);
    endtask

    // Request driver: predicts each item as it is taken, then picks the next.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                due_results_q.push_back(serve_request(request_q.pop_front()));
                sent_count++;
            end
            if (s_tvalid && !s_tready)
                drv_offer = 1'b1;
            else if (request_q.size() == 0)
                drv_offer = 1'b0;
            else if (request_q[0].drain_first && due_results_q.size() != 0)
                drv_offer = 1'b0;
            else if (sent_count >= 500 && sent_count < 700)
                drv_offer = 1'b1;
            else
                drv_offer = ($urandom_range(99) >= 7);
            s_tvalid <= drv_offer;
            if (drv_offer)
            begin
                s_tuser <= request_q[0].kind;
                s_tdata <= {request_q[0].prio, request_q[0].data};
            end
        end
    end

    // Result monitor: checks each result item against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                got.data   = m_tdata[31:0];
                got.prio   = m_tdata[63:32];
                got.valid  = m_tdata[64];
                got.status = spq_pkg::status_t'(m_tdata[66:65]);
                got.occ    = m_tdata[71:67];
                if (due_results_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: result %0d arrived with none pending: %h",
                                 results_seen, m_tdata);
                end
                else
                begin
                    want = due_results_q.pop_front();
                    if (got.valid) served_count++;
                    if (want.status == spq_pkg::ST_EMPTY) empty_count++;
                    if (want.status == spq_pkg::ST_FULL) full_count++;
                    if (got.data !== want.data || got.prio !== want.prio
                        || got.valid !== want.valid || got.status !== want.status
                        || got.occ !== want.occ)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"ERROR: result %0d: expected data %h prio %h ",
                                      "valid %b status %0d occ %0d, got data %h ",
                                      "prio %h valid %b status %0d occ %0d"},
                                     results_seen, want.data, want.prio, want.valid,
                                     want.status, want.occ, got.data, got.prio,
                                     got.valid, got.status, got.occ);
                    end
                end
            end
            // One long hold-off partway through, a stall-free stretch, random stalls elsewhere.
            if (hold_left != 0)
            begin
                hold_left--;
                rcv_ready = 1'b0;
            end
            else if (!hold_done && results_seen >= 300)
            begin
                hold_done = 1'b1;
                hold_left = 79;
                rcv_ready = 1'b0;
            end
            else if (results_seen >= 500 && results_seen < 700)
            begin
                rcv_ready = 1'b1;
            end
            else
            begin
                rcv_ready = ($urandom_range(99) >= 7);
            end
            m_tready <= rcv_ready;
        end
    end

    // Reset release.
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Stimulus and end of run.
    initial
    begin
        int unsigned   ins_pct;
        logic [31:0]   prio;
        spq_pkg::req_t kind;

        // Directed opening: empty remove, extremes, ties, fill to full.
        add_request(spq_pkg::REQ_REMOVE, 32'h0000_0000, 32'h0000_0000, 1'b0);
        add_request(spq_pkg::REQ_INSERT, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        add_request(spq_pkg::REQ_INSERT, 32'h0000_0000, 32'h8000_0000, 1'b0);
        // A tie with the front entry must go ahead of it.
        add_request(spq_pkg::REQ_INSERT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        add_request(spq_pkg::REQ_INSERT, 32'h0000_0001, 32'h0000_0000, 1'b0);
        add_request(spq_pkg::REQ_INSERT, 32'h0000_0002, 32'h0000_0000, 1'b0);
        add_request(spq_pkg::REQ_INSERT, 32'h0000_0003, 32'hFFFF_FFFF, 1'b0);
        add_request(spq_pkg::REQ_INSERT, 32'h0000_0004, 32'h8000_0000, 1'b0);
        add_request(spq_pkg::REQ_INSERT, 32'h0000_0005, 32'h7FFF_FFFE, 1'b0);
        for (int i = 0; i < 8; i++)
            add_request(spq_pkg::REQ_INSERT, 32'h5A5A_0000 + i, i * 32'h1111_1111,
                        1'b0);
        // Queue is full here, so this insert is dropped.
        add_request(spq_pkg::REQ_INSERT, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        for (int i = 0; i < 4; i++)
            add_request(spq_pkg::REQ_REMOVE, $urandom, $urandom, 1'b0);

        // Random phases, each biased toward filling, draining or holding level.
        ins_pct = 50;
        for (int i = 0; i < 1080; i++)
        begin
            if (i % 40 == 0)
                case ($urandom_range(2))
                    0: ins_pct = 15;
                    1: ins_pct = 50;
                    default: ins_pct = 85;
                endcase
            kind = ($urandom_range(99) < ins_pct) ? spq_pkg::REQ_INSERT
                                                  : spq_pkg::REQ_REMOVE;
            case ($urandom_range(9))
                0, 1, 2, 3, 4: prio = $urandom_range(3) - 2;
                5: case ($urandom_range(3))
                       0: prio = 32'h7FFF_FFFF;
                       1: prio = 32'h8000_0000;
                       2: prio = 32'h0000_0000;
                       default: prio = 32'hFFFF_FFFF;
                   endcase
                default: prio = $urandom;
            endcase
            add_request(kind, $urandom, prio, (i % 300 == 0));
        end

        @(posedge rst_n);
        while (request_q.size() != 0 || s_tvalid || due_results_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (due_results_q.size() != 0 || m_tvalid)
            mismatches++;

        $display("Ran %0d requests: %0d entries served, %0d empty removes, %0d full inserts.",
                 sent_count, served_count, empty_count, full_count);
        $display("Peak fill %0d of %0d, one long receiver stall, %0d errors.",
                 peak_count, DEPTH, mismatches);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #2ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[sorted_priority_queue.f]
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue.sv
hdl/spq_checker.sv
sim/sorted_priority_queue_test.sv
